### src/nts_pkg.sv
`timescale 1ns / 1ps

package nts_pkg;

    typedef logic [1:0] tex_fmt_t;
    typedef logic [1:0] cfg_idx_t;

    localparam tex_fmt_t FMT_BGR  = 2'd1;
    localparam tex_fmt_t FMT_BGRA = 2'd2;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam cfg_idx_t CFG_WIDTH  = 2'd0;
    localparam cfg_idx_t CFG_HEIGHT = 2'd1;
    localparam cfg_idx_t CFG_FORMAT = 2'd2;

    localparam int          COORD_W = 17;
    localparam logic [16:0] Q16_ONE = 17'h10000;
    localparam logic [7:0]  BYTE_FF = 8'hFF;
    localparam logic [7:0]  BYTE_00 = 8'h00;

endpackage

### src/nts_ram.sv
`timescale 1ns / 1ps

module nts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/nearest_texel_sampler.sv
// channel   | handshake          | payload
// ----------+--------------------+--------------------------------------------
// s_ (in)   | s_valid / s_ready  | s_cmd s_byte_addr s_byte_data s_coord_u/v
// m_ (out)  | m_valid / m_ready  | m_chan_b m_chan_g m_chan_r m_chan_a
// cfg       | cfg_we             | cfg_index cfg_wdata
//
// One transfer per cycle while s_ready is high; a sample's result is offered once it has passed every stage.
// The path has five register stages: input, scale multiply, pitch multiply,
// texel RAM read (four byte banks, one read each per cycle), output.
// Reset clears the valid bits and the configuration; texel memory is not cleared.
// A stall holds each full stage; ready runs back through the stages combinationally,
// so empty stages still fill and input is taken while a result waits.
`timescale 1ns / 1ps

module nearest_texel_sampler
    import nts_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MEM_BYTES  = 262144
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [17:0] s_byte_addr,
    input  logic [7:0]  s_byte_data,
    input  logic [16:0] s_coord_u,
    input  logic [16:0] s_coord_v,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_chan_b,
    output logic [7:0]  m_chan_g,
    output logic [7:0]  m_chan_r,
    output logic [7:0]  m_chan_a
);

    // MEM_BYTES is a power of two; read addresses wrap on its size
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PW = WW + 2;
    localparam int OW = XW + 2;
    localparam int MW = YW + PW;
    localparam int SW = MW + 1;
    localparam int AW = $clog2(MEM_BYTES);
    localparam int FW = (SW > AW) ? SW : AW;
    localparam int BD = MEM_BYTES / 4;
    localparam int BA = AW - 2;

    // configuration
    logic [8:0] tex_width_reg;
    logic [8:0] tex_height_reg;
    tex_fmt_t   tex_format_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tex_width_reg  <= '0;
            tex_height_reg <= '0;
            tex_format_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_WIDTH:  tex_width_reg  <= cfg_wdata;
                CFG_HEIGHT: tex_height_reg <= cfg_wdata;
                CFG_FORMAT: tex_format_reg <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic adv5, free4, free3, free2, free1;
    logic move3, move4;

    assign adv5  = !v5_reg || m_ready;
    assign free4 = !v4_reg || adv5;
    assign free3 = !v3_reg || free4;
    assign free2 = !v2_reg || free3;
    assign free1 = !v1_reg || free2;
    assign move3 = v3_reg && free4;
    assign move4 = v4_reg && adv5;
    assign s_ready = free1;

    // stage 1: input register with saturated coordinates
    logic        cmd1_reg;
    logic [17:0] addr1_reg;
    logic [7:0]  data1_reg;
    logic [16:0] u1_reg;
    logic [16:0] vi1_reg;
    logic [16:0] u_sat, v_sat;

    assign u_sat = (s_coord_u > Q16_ONE) ? Q16_ONE : s_coord_u;
    assign v_sat = (s_coord_v > Q16_ONE) ? Q16_ONE : s_coord_v;

    always_ff @(posedge aclk) begin
        if (free1 && s_valid) begin
            cmd1_reg  <= s_cmd;
            addr1_reg <= s_byte_addr;
            data1_reg <= s_byte_data;
            u1_reg    <= u_sat;
            vi1_reg   <= Q16_ONE - v_sat;
        end
    end

    // stage 2: texel coordinates and row pitch
    logic [12:0]      w_ext, h_ext;
    logic [WW-1:0]    w_sat, w_m1;
    logic [HW-1:0]    h_sat, h_m1;
    logic [WW+16:0]   x_prod;
    logic [HW+16:0]   y_prod;
    logic [PW-1:0]    pitch;
    logic [PW-1:0]    pitch_bgr_raw;

    assign w_ext = 13'(tex_width_reg);
    assign h_ext = 13'(tex_height_reg);
    assign w_sat = (w_ext > 13'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(w_ext);
    assign h_sat = (h_ext > 13'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(h_ext);
    assign w_m1  = (w_sat == '0) ? '0 : w_sat - WW'(1);
    assign h_m1  = (h_sat == '0) ? '0 : h_sat - HW'(1);
    assign x_prod = (WW+17)'(w_m1) * (WW+17)'(u1_reg);
    assign y_prod = (HW+17)'(h_m1) * (HW+17)'(vi1_reg);
    assign pitch_bgr_raw = PW'(w_sat) + (PW'(w_sat) << 1) + PW'(3);
    assign pitch = (tex_format_reg == FMT_BGRA) ? (PW'(w_sat) << 2)
                                                : {pitch_bgr_raw[PW-1:2], 2'b00};

    logic          cmd2_reg;
    logic [17:0]   addr2_reg;
    logic [7:0]    data2_reg;
    logic [XW-1:0] x2_reg;
    logic [YW-1:0] y2_reg;
    logic [PW-1:0] pitch2_reg;
    tex_fmt_t      fmt2_reg;

    always_ff @(posedge aclk) begin
        if (v1_reg && free2) begin
            cmd2_reg   <= cmd1_reg;
            addr2_reg  <= addr1_reg;
            data2_reg  <= data1_reg;
            x2_reg     <= XW'(x_prod >> 16);
            y2_reg     <= YW'(y_prod >> 16);
            pitch2_reg <= pitch;
            fmt2_reg   <= tex_format_reg;
        end
    end

    // stage 3: row offset and texel offset
    logic          cmd3_reg;
    logic [17:0]   addr3_reg;
    logic [7:0]    data3_reg;
    logic [MW-1:0] row3_reg;
    logic [OW-1:0] xoff3_reg;
    tex_fmt_t      fmt3_reg;

    always_ff @(posedge aclk) begin
        if (v2_reg && free3) begin
            cmd3_reg  <= cmd2_reg;
            addr3_reg <= addr2_reg;
            data3_reg <= data2_reg;
            row3_reg  <= MW'(y2_reg) * MW'(pitch2_reg);
            xoff3_reg <= (fmt2_reg == FMT_BGRA) ? (OW'(x2_reg) << 2)
                                                : OW'(x2_reg) + (OW'(x2_reg) << 1);
            fmt3_reg  <= fmt2_reg;
        end
    end

    // texel RAM: four byte banks, lane = address bits [1:0]
    logic [FW-1:0] base_full;
    logic [AW-1:0] base;
    logic [AW-1:0] waddr_full;
    logic          wr_ok;
    logic [3:0]    bank_we;
    logic          ram_re;
    logic [7:0]    bank_rdata [4];

    assign base_full  = FW'(row3_reg) + FW'(xoff3_reg);
    assign base       = base_full[AW-1:0];
    assign waddr_full = AW'(addr3_reg);
    assign wr_ok      = move3 && (cmd3_reg == CMD_WRITE) && (32'(addr3_reg) < 32'(MEM_BYTES));
    assign ram_re     = move3 && (cmd3_reg == CMD_SAMPLE);

    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [BA-1:0] raddr;

        assign raddr = (2'(k) < base[1:0]) ? base[AW-1:2] + BA'(1) : base[AW-1:2];
        assign bank_we[k] = wr_ok && (addr3_reg[1:0] == 2'(k));

        nts_ram #(
            .WIDTH(8),
            .DEPTH(BD)
        ) u_ram (
            .aclk  (aclk),
            .we    (bank_we[k]),
            .waddr (waddr_full[AW-1:2]),
            .wdata (data3_reg),
            .re    (ram_re),
            .raddr (raddr),
            .rdata (bank_rdata[k])
        );
    end

    // stage 4: RAM data held in the banks
    logic [1:0] lane4_reg;
    tex_fmt_t   fmt4_reg;

    always_ff @(posedge aclk) begin
        if (ram_re) begin
            lane4_reg <= base[1:0];
            fmt4_reg  <= fmt3_reg;
        end
    end

    logic [7:0] texel [4];
    logic [7:0] b_next, g_next, r_next, a_next;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            texel[j] = bank_rdata[2'(lane4_reg + 2'(j))];
        end
        case (fmt4_reg)
            FMT_BGRA: begin
                b_next = texel[0];
                g_next = texel[1];
                r_next = texel[2];
                a_next = texel[3];
            end
            FMT_BGR: begin
                b_next = texel[0];
                g_next = texel[1];
                r_next = texel[2];
                a_next = BYTE_FF;
            end
            default: begin
                b_next = BYTE_FF;
                g_next = BYTE_00;
                r_next = BYTE_00;
                a_next = BYTE_FF;
            end
        endcase
    end

    // stage 5: output register
    logic [7:0] chan_b_reg, chan_g_reg, chan_r_reg, chan_a_reg;

    always_ff @(posedge aclk) begin
        if (move4) begin
            chan_b_reg <= b_next;
            chan_g_reg <= g_next;
            chan_r_reg <= r_next;
            chan_a_reg <= a_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (free1) begin
                v1_reg <= s_valid;
            end
            if (free2) begin
                v2_reg <= v1_reg;
            end
            if (free3) begin
                v3_reg <= v2_reg;
            end
            if (free4) begin
                v4_reg <= v3_reg && (cmd3_reg == CMD_SAMPLE);
            end
            if (adv5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    assign m_valid  = v5_reg;
    assign m_chan_b = chan_b_reg;
    assign m_chan_g = chan_g_reg;
    assign m_chan_r = chan_r_reg;
    assign m_chan_a = chan_a_reg;

`ifndef SYNTHESIS
    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        move3 && (cmd3_reg == CMD_WRITE) |=> !v4_reg)
        else $error("write transfer reached the read stage");

    a_one_bank_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(bank_we))
        else $error("more than one bank written");

    a_not_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> v1_reg && v2_reg && v3_reg && v4_reg && v5_reg)
        else $error("input stalled with an empty stage");

    a_read_held: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg && !adv5 |=> v4_reg && $stable(lane4_reg) && $stable(fmt4_reg))
        else $error("read stage lost its item during a stall");
`endif

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import nts_pkg::*;

    localparam int TEX_MAX_W   = 256;
    localparam int TEX_MAX_H   = 256;
    localparam int TEX_BYTES   = 262144;
    localparam int PIPE_DEPTH  = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PCT_HEAVY   = 48;
    localparam int PCT_LIGHT   = 12;

    localparam tex_fmt_t FMT_NONE  = 2'd0;
    localparam tex_fmt_t FMT_SPARE = 2'd3;
    localparam cfg_idx_t CFG_SPARE = 2'd3;

    typedef enum {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic        cmd;
        logic [17:0] addr;
        logic [7:0]  data;
        logic [16:0] u;
        logic [16:0] v;
    } req_t;

    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
        logic [7:0] a;
    } texel_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [1:0]  cfg_index   = '0;
    logic [8:0]  cfg_wdata   = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic        s_cmd       = CMD_WRITE;
    logic [17:0] s_byte_addr = '0;
    logic [7:0]  s_byte_data = '0;
    logic [16:0] s_coord_u   = '0;
    logic [16:0] s_coord_v   = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [7:0]  m_chan_b;
    logic [7:0]  m_chan_g;
    logic [7:0]  m_chan_r;
    logic [7:0]  m_chan_a;

    // texture setup as the block sees it
    logic [8:0] tex_w   = '0;
    logic [8:0] tex_h   = '0;
    tex_fmt_t   tex_fmt = FMT_NONE;

    logic [7:0] texels   [TEX_BYTES];
    bit         byte_set [TEX_BYTES];

    req_t   req_queue[$];
    texel_t texel_due[$];
    req_t   drv_req;
    texel_t want;
    texel_t got;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_len       = 0;
    int hold_seq       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int cycles         = 0;
    int faults         = 0;
    int n_in           = 0;
    int n_out          = 0;
    int in_stalls      = 0;
    int setups         = 0;

    nearest_texel_sampler #(
        .MAX_WIDTH (TEX_MAX_W),
        .MAX_HEIGHT(TEX_MAX_H),
        .MEM_BYTES (TEX_BYTES)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_byte_addr(s_byte_addr),
        .s_byte_data(s_byte_data),
        .s_coord_u  (s_coord_u),
        .s_coord_v  (s_coord_v),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_chan_b   (m_chan_b),
        .m_chan_g   (m_chan_g),
        .m_chan_r   (m_chan_r),
        .m_chan_a   (m_chan_a)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // byte address of the texel picked by u,v and its byte count (0 when the format is neither BGR nor BGRA)
    function automatic void texel_addr(input logic [16:0] u_in, input logic [16:0] v_in,
                                       output int unsigned base, output int unsigned nbytes);
        int unsigned u, v, w, h, x, y;
        u = (u_in > Q16_ONE) ? Q16_ONE : u_in;
        v = (v_in > Q16_ONE) ? Q16_ONE : v_in;
        w = (tex_w > TEX_MAX_W) ? TEX_MAX_W : tex_w;
        h = (tex_h > TEX_MAX_H) ? TEX_MAX_H : tex_h;
        x = (w == 0) ? 0 : ((w - 1) * u) >> 16;
        y = (h == 0) ? 0 : ((h - 1) * (Q16_ONE - v)) >> 16;
        case (tex_fmt)
            FMT_BGRA: begin
                base   = y * 4 * w + 4 * x;
                nbytes = 4;
            end
            FMT_BGR: begin
                base   = y * (((24 * w + 31) & ~32'd31) / 8) + 3 * x;
                nbytes = 3;
            end
            default: begin
                base   = 0;
                nbytes = 0;
            end
        endcase
        base = base % TEX_BYTES;
    endfunction

    function automatic texel_t predict_texel(logic [16:0] u, logic [16:0] v);
        texel_t t;
        int unsigned base, nbytes;
        texel_addr(u, v, base, nbytes);
        if (nbytes == 0)
            return {BYTE_FF, BYTE_00, BYTE_00, BYTE_FF};
        t.b = texels[base];
        t.g = texels[(base + 1) % TEX_BYTES];
        t.r = texels[(base + 2) % TEX_BYTES];
        t.a = (nbytes == 4) ? texels[(base + 3) % TEX_BYTES] : BYTE_FF;
        return t;
    endfunction

    function automatic logic [16:0] rand_coord();
        case ($urandom_range(9))
            0: return '0;
            1: return Q16_ONE;
            2: return 17'($urandom_range(17'h1FFFF, 17'h10001));
            3: return Q16_ONE - 17'd1;
            default: return 17'($urandom_range(Q16_ONE));
        endcase
    endfunction

    task automatic queue_write(int unsigned addr, logic [7:0] data);
        req_t r;
        r.cmd  = CMD_WRITE;
        r.addr = 18'(addr);
        r.data = data;
        r.u    = 17'($urandom);
        r.v    = 17'($urandom);
        byte_set[r.addr] = 1'b1;
        req_queue.push_back(r);
    endtask

    // fills any texel byte not yet written before the sample goes out
    task automatic queue_sample(logic [16:0] u, logic [16:0] v);
        req_t r;
        int unsigned base, nbytes;
        texel_addr(u, v, base, nbytes);
        for (int k = 0; k < nbytes; k++)
            if (!byte_set[(base + k) % TEX_BYTES])
                queue_write((base + k) % TEX_BYTES, 8'($urandom));
        r.cmd  = CMD_SAMPLE;
        r.addr = 18'($urandom);
        r.data = 8'($urandom);
        r.u    = u;
        r.v    = v;
        req_queue.push_back(r);
    endtask

    task automatic settle();
        while (req_queue.size() != 0 || s_valid || texel_due.size() != 0)
            @(negedge aclk);
        repeat (PIPE_DEPTH + 3) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [8:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_WIDTH:  tex_w = val;
            CFG_HEIGHT: tex_h = val;
            CFG_FORMAT: tex_fmt = val[1:0];
            default: ;
        endcase
    endtask

    task automatic set_texture(logic [8:0] w, logic [8:0] h, tex_fmt_t fmt);
        settle();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_FORMAT, {7'($urandom), fmt});
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        setups++;
    endtask

    task automatic run_random(logic [8:0] w, logic [8:0] h, tex_fmt_t fmt,
                              idle_mode_t mode, int n, bit pause_mid);
        int unsigned base, nbytes;
        set_texture(w, h, fmt);
        src_idle_pct   = (mode == IDLE_SRC)  ? PCT_HEAVY : (mode == IDLE_BOTH) ? PCT_LIGHT : 0;
        sink_stall_pct = (mode == IDLE_SINK) ? PCT_HEAVY : (mode == IDLE_BOTH) ? PCT_LIGHT : 0;
        for (int i = 0; i < n; i++) begin
            if (pause_mid && i == n / 2)
                settle();
            if ($urandom_range(9) < 3) begin
                if ($urandom_range(1)) begin
                    texel_addr(rand_coord(), rand_coord(), base, nbytes);
                    queue_write((base + $urandom_range(3)) % TEX_BYTES, 8'($urandom));
                end else begin
                    queue_write($urandom_range(TEX_BYTES - 1), 8'($urandom));
                end
            end else begin
                queue_sample(rand_coord(), rand_coord());
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (req_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                drv_req = req_queue.pop_front();
                s_valid     <= 1'b1;
                s_cmd       <= drv_req.cmd;
                s_byte_addr <= drv_req.addr;
                s_byte_data <= drv_req.data;
                s_coord_u   <= drv_req.u;
                s_coord_v   <= drv_req.v;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side: random stalls plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                n_in++;
                if (s_cmd == CMD_WRITE) begin
                    if (s_byte_addr < TEX_BYTES)
                        texels[s_byte_addr] = s_byte_data;
                end else begin
                    texel_due.push_back(predict_texel(s_coord_u, s_coord_v));
                end
            end
            if (s_valid && !s_ready)
                in_stalls++;
            if (m_valid && m_ready) begin
                got = {m_chan_b, m_chan_g, m_chan_r, m_chan_a};
                if (texel_due.size() == 0) begin
                    faults++;
                    if (faults <= 10)
                        $display("unexpected texel b=%02h g=%02h r=%02h a=%02h",
                                 got.b, got.g, got.r, got.a);
                end else begin
                    want = texel_due.pop_front();
                    n_out++;
                    if (got.b != want.b || got.g != want.g || got.r != want.r
                            || got.a != want.a) begin
                        faults++;
                        if (faults <= 10)
                            $display("texel %0d: expected b=%02h g=%02h r=%02h a=%02h, %s",
                                     n_out, want.b, want.g, want.r, want.a,
                                     $sformatf("got b=%02h g=%02h r=%02h a=%02h",
                                               got.b, got.g, got.r, got.a));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles with %0d texels outstanding",
                     cycles, texel_due.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: byte extremes, corners, saturation, every format and size corner
        set_texture(4, 4, FMT_BGRA);
        queue_write(0, BYTE_00);
        queue_write(TEX_BYTES - 1, BYTE_FF);
        queue_sample('0, Q16_ONE);
        queue_sample(Q16_ONE, '0);
        queue_sample(17'h1FFFF, 17'h1FFFF);
        queue_sample(17'h08000, 17'h08000);

        set_texture(4, 4, FMT_NONE);
        queue_sample(rand_coord(), rand_coord());
        settle();
        write_reg(CFG_SPARE, 9'h1FF);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        queue_sample(rand_coord(), rand_coord());

        set_texture(4, 4, FMT_SPARE);
        queue_sample(rand_coord(), rand_coord());

        set_texture(5, 3, FMT_BGR);
        queue_sample(Q16_ONE, Q16_ONE);
        queue_sample(Q16_ONE, '0);
        queue_sample('0, '0);

        set_texture(0, 0, FMT_BGR);
        queue_sample(rand_coord(), rand_coord());

        set_texture(511, 300, FMT_BGRA);
        queue_sample(Q16_ONE, '0);
        queue_sample('0, Q16_ONE);

        run_random(8, 8, FMT_BGRA, IDLE_NONE, 40, 1'b0);
        run_random(5, 7, FMT_BGR, IDLE_SRC, 40, 1'b1);
        run_random(256, 256, FMT_BGR, IDLE_SINK, 30, 1'b0);
        run_random(3, 1, FMT_BGRA, IDLE_BOTH, 40, 1'b0);
        run_random(1, 1, FMT_BGR, IDLE_SINK, 30, 1'b0);
        run_random(511, 511, FMT_BGRA, IDLE_BOTH, 20, 1'b0);

        // back-pressure: result side held off while samples keep coming
        set_texture(4, 4, FMT_BGRA);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        for (int a = 0; a < 64; a++)
            queue_write(a, 8'($urandom));
        hold_len = 300;
        hold_seq++;
        repeat (60) queue_sample(rand_coord(), rand_coord());
        settle();
        repeat (30) queue_sample(rand_coord(), rand_coord());

        for (int p = 0; p < 5; p++)
            run_random(9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)),
                       tex_fmt_t'($urandom_range(3)), idle_mode_t'(p % 4), 35, 1'b0);

        settle();
        $display("%0d transfers in, %0d texels checked, over %0d texture setups",
                 n_in, n_out, setups);
        $display("input held back for %0d cycles; %0d faults", in_stalls, faults);
        if (faults == 0 && texel_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
